// ----- rtl/stencil_halo_address_generator_defines.svh -----
// Assertion macros used by the halo address generator checker.
`ifndef STENCIL_HALO_ADDRESS_GENERATOR_DEFINES_SVH
`define STENCIL_HALO_ADDRESS_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SHAG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SHAG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/shag_pkg.sv -----
// Shared widths, register indexes and control/status types of the halo address generator.
package shag_pkg;

  localparam int HalfW  = 5;
  localparam int BoundW = 8;
  localparam int DimW   = 11;
  localparam int TsW    = 16;
  localparam int BsW    = 32;
  localparam int GridW  = 30;
  localparam int BackW  = 48;
  localparam int IdxW   = 3;
  localparam int DataW  = 32;
  localparam int PlaneW = 2 * DimW;

  localparam logic [IdxW-1:0] REG_HALF  = 3'd0;
  localparam logic [IdxW-1:0] REG_BOUND = 3'd1;
  localparam logic [IdxW-1:0] REG_WX    = 3'd2;
  localparam logic [IdxW-1:0] REG_WZ    = 3'd3;
  localparam logic [IdxW-1:0] REG_WY    = 3'd4;
  localparam logic [IdxW-1:0] REG_3D    = 3'd5;
  localparam logic [IdxW-1:0] REG_BSIZE = 3'd6;
  localparam logic [IdxW-1:0] REG_MODE  = 3'd7;

  typedef struct packed {
    logic [HalfW-1:0]  half;
    logic [BoundW-1:0] bound;
    logic [DimW-1:0]   wx;
    logic [DimW-1:0]   wz;
    logic [DimW-1:0]   wy;
    logic              three_d;
    logic [BsW-1:0]    bsize;
    logic              restore;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic seek;
    logic mul1;
    logic mul2;
    logic adv;
    logic empty;
    logic fin;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic seek_ok;
    logic seek_end;
    logic wrap;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/stencil_halo_address_generator.sv -----
// Top level of the stencil halo address generator.
//
//   channel  direction  payload                                      handshake
//   in       input      step_num                                     in_valid / in_ready
//   out      output     grid_address, backup_address, to_grid,       out_valid / out_ready
//                       last, empty_res
//   cfg      input      cfg_index, cfg_data                          cfg_valid / cfg_ready
//
// A request inside a running sequence passes through the accept, two registered multiplies
// (B*wx, then A*wx*wz), one add/advance step and the output load before the next accept.
// The first request of a sequence adds a phase search before the multiplies; a phase change
// adds a search after the advance step. An empty sequence takes the accept, the search and
// the load. rst_n is synchronous; it loads the register defaults and idles the walk.
// The result sits in an output register; the load waits while out_valid is high and out_ready
// low, which also holds off the next request. cfg_ready is always high.
module stencil_halo_address_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [shag_pkg::TsW-1:0]       in_step_num,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [shag_pkg::GridW-1:0]     out_grid_address,
  output logic [shag_pkg::BackW-1:0]     out_backup_address,
  output logic                           out_to_grid,
  output logic                           out_last,
  output logic                           out_empty_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [shag_pkg::IdxW-1:0]      cfg_index,
  input  logic [shag_pkg::DataW-1:0]     cfg_data
);

  shag_pkg::cfg_t  cfg;
  shag_pkg::cmd_t  cmd;
  shag_pkg::stat_t st;

  shag_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  shag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  shag_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .st                 (st),
    .in_step_num        (in_step_num),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_grid_address   (out_grid_address),
    .out_backup_address (out_backup_address),
    .out_to_grid        (out_to_grid),
    .out_last           (out_last),
    .out_empty_res      (out_empty_res)
  );

endmodule

// ----- rtl/shag_regs.sv -----
// Configuration register file of the halo address generator.
module shag_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [shag_pkg::IdxW-1:0]     cfg_index,
  input  logic [shag_pkg::DataW-1:0]    cfg_data,
  output shag_pkg::cfg_t                cfg
);

  shag_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half    <= 5'd4;
      cfg_r.bound   <= '0;
      cfg_r.wx      <= 11'd1;
      cfg_r.wz      <= 11'd1;
      cfg_r.wy      <= 11'd1;
      cfg_r.three_d <= 1'b0;
      cfg_r.bsize   <= '0;
      cfg_r.restore <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        shag_pkg::REG_HALF:  cfg_r.half    <= cfg_data[shag_pkg::HalfW-1:0];
        shag_pkg::REG_BOUND: cfg_r.bound   <= cfg_data[shag_pkg::BoundW-1:0];
        shag_pkg::REG_WX:    cfg_r.wx      <= cfg_data[shag_pkg::DimW-1:0];
        shag_pkg::REG_WZ:    cfg_r.wz      <= cfg_data[shag_pkg::DimW-1:0];
        shag_pkg::REG_WY:    cfg_r.wy      <= cfg_data[shag_pkg::DimW-1:0];
        shag_pkg::REG_3D:    cfg_r.three_d <= cfg_data[0];
        shag_pkg::REG_BSIZE: cfg_r.bsize   <= cfg_data[shag_pkg::BsW-1:0];
        shag_pkg::REG_MODE:  cfg_r.restore <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/shag_ctrl.sv -----
// Sequencing state machine of the halo address generator.
module shag_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  shag_pkg::stat_t     st,
  output shag_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SEEK  = 7'b0000010,
    S_MUL1  = 7'b0000100,
    S_MUL2  = 7'b0001000,
    S_ADV   = 7'b0010000,
    S_SEEKN = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_seq_r, in_seq_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    in_seq_nxt = in_seq_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_seq_r) begin
            state_nxt = S_MUL1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SEEK;
          end
        end
      end
      S_SEEK: begin
        cmd.seek = 1'b1;
        if (st.seek_ok) begin
          in_seq_nxt = 1'b1;
          state_nxt  = S_MUL1;
        end else if (st.seek_end) begin
          cmd.empty = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = st.wrap ? S_SEEKN : S_OUT;
      end
      S_SEEKN: begin
        // phase ran out: find the next non-empty one or close the sequence
        cmd.seek = 1'b1;
        if (st.seek_ok) begin
          state_nxt = S_OUT;
        end else if (st.seek_end) begin
          cmd.fin    = 1'b1;
          in_seq_nxt = 1'b0;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_seq_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_seq_r <= in_seq_nxt;
    end
  end

endmodule

// ----- rtl/shag_dp.sv -----
// Counters, range logic, address arithmetic and output register of the halo address generator.
module shag_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  shag_pkg::cfg_t                 cfg,
  input  shag_pkg::cmd_t                 cmd,
  output shag_pkg::stat_t                st,
  input  logic [shag_pkg::TsW-1:0]       in_step_num,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [shag_pkg::GridW-1:0]     out_grid_address,
  output logic [shag_pkg::BackW-1:0]     out_backup_address,
  output logic                           out_to_grid,
  output logic                           out_last,
  output logic                           out_empty_res
);

  localparam int CW = shag_pkg::DimW;
  localparam int GW = shag_pkg::GridW;
  localparam int BW = shag_pkg::BackW;

  localparam logic [1:0] PH_XF   = 2'd0;
  localparam logic [1:0] PH_ZF   = 2'd1;
  localparam logic [1:0] PH_YF   = 2'd2;
  localparam logic [1:0] PH_NONE = 2'd3;

  typedef struct packed {
    logic [CW-1:0] lo0;
    logic [CW-1:0] hi0;
    logic [CW-1:0] lo1;
    logic [CW-1:0] hi1;
    logic [CW-1:0] lo2;
    logic [CW-1:0] hi2;
  } rng_t;

  function automatic rng_t get_rng(input logic [1:0] p, input shag_pkg::cfg_t c);
    logic [CW-1:0] off;
    logic [CW-1:0] half_w;
    logic [CW-1:0] ys;
    logic [CW-1:0] ye;
    logic [CW-1:0] ze;
    logic [CW-1:0] xe;
    rng_t          r;
    off    = CW'(c.half) + CW'(c.bound);
    half_w = CW'(c.half);
    ys     = c.three_d ? off : '0;
    ye     = c.three_d ? c.wy : CW'(1);
    ze     = (c.wz >= off) ? c.wz - off : '0;
    xe     = (c.wx >= off) ? c.wx - off : '0;
    case (p)
      PH_XF: begin
        r.lo0 = ys;  r.hi0 = ye;
        r.lo1 = off; r.hi1 = ze;
        r.lo2 = '0;  r.hi2 = half_w;
      end
      PH_ZF: begin
        r.lo0 = ys;  r.hi0 = ye;
        r.lo1 = '0;  r.hi1 = half_w;
        r.lo2 = off; r.hi2 = xe;
      end
      default: begin
        r.lo0 = '0;  r.hi0 = c.three_d ? half_w : '0;
        r.lo1 = off; r.hi1 = ze;
        r.lo2 = off; r.hi2 = xe;
      end
    endcase
    return r;
  endfunction

  logic [1:0]            phase_r;
  logic [1:0]            seek_p_r;
  logic [CW-1:0]         outer_r;
  logic [CW-1:0]         mid_r;
  logic [CW-1:0]         inner_r;
  logic                  pm_r;
  logic [shag_pkg::BsW-1:0] elem_r;
  logic [BW-1:0]         base_r;

  logic [shag_pkg::PlaneW-1:0] plane_r;
  logic [GW-1:0]         bwx_r;
  logic [GW-1:0]         a_r;
  logic [GW-1:0]         c_r;
  logic [GW-1:0]         aplane_r;

  logic [GW-1:0]         res_grid_r;
  logic [BW-1:0]         res_back_r;
  logic                  res_to_grid_r;
  logic                  res_last_r;
  logic                  res_empty_r;

  logic                  out_valid_r;
  logic [GW-1:0]         out_grid_r;
  logic [BW-1:0]         out_back_r;
  logic                  out_to_grid_r;
  logic                  out_last_r;
  logic                  out_empty_r;

  rng_t                  rng_cur;
  rng_t                  rng_seek;
  logic [CW:0]           inner_inc;
  logic [CW:0]           mid_inc;
  logic [CW:0]           outer_inc;
  logic                  inner_wrap;
  logic                  mid_wrap;
  logic                  outer_wrap;
  logic [CW-1:0]         crd;
  logic [CW-1:0]         span;
  logic [GW-1:0]         face;
  logic [GW-1:0]         a_sel;
  logic [GW-1:0]         b_sel;
  logic [GW-1:0]         c_sel;
  logic [BW:0]           back_sum;

  assign rng_cur  = get_rng(phase_r, cfg);
  assign rng_seek = get_rng(seek_p_r, cfg);

  assign inner_inc  = {1'b0, inner_r} + (CW+1)'(1);
  assign mid_inc    = {1'b0, mid_r} + (CW+1)'(1);
  assign outer_inc  = {1'b0, outer_r} + (CW+1)'(1);
  assign inner_wrap = !(inner_inc < {1'b0, rng_cur.hi2});
  assign mid_wrap   = !(mid_inc < {1'b0, rng_cur.hi1});
  assign outer_wrap = !(outer_inc < {1'b0, rng_cur.hi0});

  assign st.seek_ok  = (seek_p_r != PH_NONE) && (rng_seek.hi0 > rng_seek.lo0) &&
                       (rng_seek.hi1 > rng_seek.lo1) && (rng_seek.hi2 > rng_seek.lo2);
  assign st.seek_end = (seek_p_r == PH_YF) || (seek_p_r == PH_NONE);
  assign st.wrap     = pm_r && inner_wrap && mid_wrap && outer_wrap;
  assign st.out_free = !out_valid_r || out_ready;

  // grid address = A*plane + B*wx + C; the face coordinate lands in A, B or C by phase
  always_comb begin
    case (phase_r)
      PH_XF: begin
        crd  = inner_r;
        span = cfg.wx;
      end
      PH_ZF: begin
        crd  = mid_r;
        span = cfg.wz;
      end
      default: begin
        crd  = outer_r;
        span = cfg.wy;
      end
    endcase
    face = pm_r ? GW'(span) - GW'(cfg.bound) - GW'(1) - GW'(crd)
                : GW'(cfg.bound) + GW'(crd);
    case (phase_r)
      PH_XF: begin
        a_sel = GW'(outer_r);
        b_sel = GW'(mid_r);
        c_sel = face;
      end
      PH_ZF: begin
        a_sel = GW'(outer_r);
        b_sel = face;
        c_sel = GW'(inner_r);
      end
      default: begin
        a_sel = face;
        b_sel = GW'(mid_r);
        c_sel = GW'(inner_r);
      end
    endcase
  end

  assign back_sum = {1'b0, base_r} + (BW+1)'(elem_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_XF;
      seek_p_r <= PH_XF;
      outer_r  <= '0;
      mid_r    <= '0;
      inner_r  <= '0;
      pm_r     <= 1'b0;
      elem_r   <= '0;
      base_r   <= '0;
    end else begin
      if (cmd.start) begin
        base_r   <= BW'(in_step_num) * BW'(cfg.bsize);
        elem_r   <= '0;
        seek_p_r <= PH_XF;
      end
      if (cmd.seek) begin
        if (st.seek_ok) begin
          phase_r <= seek_p_r;
          outer_r <= rng_seek.lo0;
          mid_r   <= rng_seek.lo1;
          inner_r <= rng_seek.lo2;
          pm_r    <= 1'b0;
        end else begin
          seek_p_r <= seek_p_r + 2'd1;
        end
      end
      if (cmd.adv) begin
        elem_r <= elem_r + shag_pkg::BsW'(1);
        if (!pm_r) begin
          pm_r <= 1'b1;
        end else begin
          pm_r <= 1'b0;
          if (!inner_wrap) begin
            inner_r <= inner_inc[CW-1:0];
          end else begin
            inner_r <= rng_cur.lo2;
            if (!mid_wrap) begin
              mid_r <= mid_inc[CW-1:0];
            end else begin
              mid_r   <= rng_cur.lo1;
              outer_r <= outer_inc[CW-1:0];
              if (outer_wrap) begin
                seek_p_r <= phase_r + 2'd1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      plane_r <= shag_pkg::PlaneW'(cfg.wx) * shag_pkg::PlaneW'(cfg.wz);
      bwx_r   <= b_sel * GW'(cfg.wx);
      a_r     <= a_sel;
      c_r     <= c_sel;
    end
    if (cmd.mul2) begin
      aplane_r <= a_r * GW'(plane_r);
    end
    if (cmd.adv) begin
      res_grid_r    <= aplane_r + bwx_r + c_r;
      res_back_r    <= back_sum[BW] ? {BW{1'b1}} : back_sum[BW-1:0];
      res_to_grid_r <= cfg.restore;
      res_last_r    <= 1'b0;
      res_empty_r   <= 1'b0;
    end
    if (cmd.empty) begin
      res_grid_r    <= '0;
      res_back_r    <= '0;
      res_to_grid_r <= cfg.restore;
      res_last_r    <= 1'b1;
      res_empty_r   <= 1'b1;
    end
    if (cmd.fin) begin
      res_last_r <= 1'b1;
    end
    if (cmd.out_load) begin
      out_grid_r    <= res_grid_r;
      out_back_r    <= res_back_r;
      out_to_grid_r <= res_to_grid_r;
      out_last_r    <= res_last_r;
      out_empty_r   <= res_empty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_grid_address   = out_grid_r;
  assign out_backup_address = out_back_r;
  assign out_to_grid        = out_to_grid_r;
  assign out_last           = out_last_r;
  assign out_empty_res      = out_empty_r;

endmodule

// ----- rtl/shag_checker.sv -----
// Port-level checker of the halo address generator, bound to the top level.
`include "stencil_halo_address_generator_defines.svh"

module shag_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [shag_pkg::GridW-1:0]     out_grid_address,
  input logic [shag_pkg::BackW-1:0]     out_backup_address,
  input logic                           out_to_grid,
  input logic                           out_last,
  input logic                           out_empty_res
);

  // a stalled result keeps its payload
  `SHAG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_grid_address) && $stable(out_backup_address) &&
    $stable(out_to_grid) && $stable(out_last) && $stable(out_empty_res),
    "result changed while stalled")

  // an empty sequence reports a single closing result with zero addresses
  `SHAG_ASSERT_NOW(a_empty_form, out_valid && out_empty_res,
    out_last && (out_grid_address == '0) && (out_backup_address == '0),
    "empty result is malformed")

  // the block is not ready again right after it takes a request
  `SHAG_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "ready right after a request was taken")

endmodule

bind stencil_halo_address_generator shag_checker u_shag_checker (.*);

// ----- verif/tb_stencil_halo_address_generator.sv -----
// Testbench for the stencil halo address generator: directed and random walks against a predictor.
`timescale 1ns / 100ps

module tb_stencil_halo_address_generator;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int QUIET_ITEMS   = 120;
  localparam int CmpW          = shag_pkg::BackW;
  localparam logic [shag_pkg::BackW-1:0] BACKUP_TOP = '1;

  typedef enum logic [1:0] {FACE_X, FACE_Z, FACE_Y} face_t;

  typedef struct {
    logic [shag_pkg::GridW-1:0] grid;
    logic [shag_pkg::BackW-1:0] backup;
    logic                       to_grid;
    logic                       last;
    logic                       empty;
  } halo_result_t;

  // Tracks the strip walk and holds the address pairs still owed by the block.
  class halo_walk_t;
    shag_pkg::cfg_t  regs;
    face_t           face;
    int unsigned     outer, middle, inner, elem_idx;
    bit              member, walking;
    longint unsigned base;
    int unsigned     lo[3], hi[3];
    halo_result_t    pending_addresses[$];
    int              mismatches;

    function new();
      regs       = '0;
      regs.half  = 5'd4;
      regs.wx    = 11'd1;
      regs.wz    = 11'd1;
      regs.wy    = 11'd1;
      face       = FACE_X;
      outer      = 0;
      middle     = 0;
      inner      = 0;
      elem_idx   = 0;
      member     = 1'b0;
      walking    = 1'b0;
      base       = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [shag_pkg::IdxW-1:0] idx, logic [shag_pkg::DataW-1:0] data);
      case (idx)
        shag_pkg::REG_HALF:  regs.half    = data[shag_pkg::HalfW-1:0];
        shag_pkg::REG_BOUND: regs.bound   = data[shag_pkg::BoundW-1:0];
        shag_pkg::REG_WX:    regs.wx      = data[shag_pkg::DimW-1:0];
        shag_pkg::REG_WZ:    regs.wz      = data[shag_pkg::DimW-1:0];
        shag_pkg::REG_WY:    regs.wy      = data[shag_pkg::DimW-1:0];
        shag_pkg::REG_3D:    regs.three_d = data[0];
        shag_pkg::REG_BSIZE: regs.bsize   = data[shag_pkg::BsW-1:0];
        shag_pkg::REG_MODE:  regs.restore = data[0];
        default: ;
      endcase
    endfunction

    // outer/middle/inner loop bounds of one face
    function void face_ranges(face_t f);
      int unsigned off, ys, ye, ze, xe;
      off = 32'(regs.half) + 32'(regs.bound);
      ys  = regs.three_d ? off : 32'd0;
      ye  = regs.three_d ? 32'(regs.wy) : 32'd1;
      ze  = (32'(regs.wz) >= off) ? 32'(regs.wz) - off : 32'd0;
      xe  = (32'(regs.wx) >= off) ? 32'(regs.wx) - off : 32'd0;
      case (f)
        FACE_X: begin
          lo = '{ys, off, 32'd0};
          hi = '{ye, ze, 32'(regs.half)};
        end
        FACE_Z: begin
          lo = '{ys, 32'd0, off};
          hi = '{ye, 32'(regs.half), xe};
        end
        default: begin
          lo = '{32'd0, off, off};
          hi = '{regs.three_d ? 32'(regs.half) : 32'd0, ze, xe};
        end
      endcase
    endfunction

    function bit seek_face(int first);
      for (int f = first; f < 3; f++) begin
        face_ranges(face_t'(f));
        if (hi[0] > lo[0] && hi[1] > lo[1] && hi[2] > lo[2]) begin
          face   = face_t'(f);
          outer  = lo[0];
          middle = lo[1];
          inner  = lo[2];
          member = 1'b0;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function bit next_member();
      if (!member) begin
        member = 1'b1;
        return 1'b1;
      end
      member = 1'b0;
      face_ranges(face);
      inner++;
      if (inner < hi[2]) return 1'b1;
      inner = lo[2];
      middle++;
      if (middle < hi[1]) return 1'b1;
      middle = lo[1];
      outer++;
      if (outer < hi[0]) return 1'b1;
      return seek_face(int'(face) + 1);
    endfunction

    // far-side coordinates may underflow; the sum wraps and only the low bits count
    function logic [shag_pkg::GridW-1:0] grid_address();
      longint unsigned wx, wz, wy, plane, b, o, m, n, a;
      wx    = regs.wx;
      wz    = regs.wz;
      wy    = regs.wy;
      plane = wx * wz;
      b     = regs.bound;
      o     = outer;
      m     = middle;
      n     = inner;
      case (face)
        FACE_X:  a = o * plane + m * wx + (member ? wx - b - 1 - n : b + n);
        FACE_Z:  a = o * plane + n + (member ? wz - b - 1 - m : b + m) * wx;
        default: a = m * wx + n + (member ? wy - b - 1 - o : b + o) * plane;
      endcase
      return a[shag_pkg::GridW-1:0];
    endfunction

    function void step(logic [shag_pkg::TsW-1:0] ts);
      halo_result_t    r;
      longint unsigned backup;
      r.to_grid = regs.restore;
      r.empty   = 1'b0;
      if (!walking) begin
        base     = 64'(ts) * 64'(regs.bsize);
        elem_idx = 0;
        if (!seek_face(0)) begin
          r.grid   = '0;
          r.backup = '0;
          r.last   = 1'b1;
          r.empty  = 1'b1;
          pending_addresses.push_back(r);
          return;
        end
        walking = 1'b1;
      end
      backup = base + 64'(elem_idx);
      if (backup > 64'(BACKUP_TOP)) backup = 64'(BACKUP_TOP);
      r.grid   = grid_address();
      r.backup = backup[shag_pkg::BackW-1:0];
      elem_idx++;
      r.last = !next_member();
      if (r.last) walking = 1'b0;
      pending_addresses.push_back(r);
    endfunction

    function void compare(string field, logic [CmpW-1:0] want, logic [CmpW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void match(halo_result_t got);
      halo_result_t want;
      if (pending_addresses.size() == 0) begin
        $display("%0t: result with no request outstanding, grid %h backup %h",
                 $time, got.grid, got.backup);
        mismatches++;
        return;
      end
      want = pending_addresses.pop_front();
      compare("grid_address", CmpW'(want.grid), CmpW'(got.grid));
      compare("backup_address", want.backup, got.backup);
      compare("to_grid", CmpW'(want.to_grid), CmpW'(got.to_grid));
      compare("last", CmpW'(want.last), CmpW'(got.last));
      compare("empty_res", CmpW'(want.empty), CmpW'(got.empty));
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [shag_pkg::TsW-1:0]      in_step_num;
  logic                          out_valid;
  logic                          out_ready;
  logic [shag_pkg::GridW-1:0]    out_grid_address;
  logic [shag_pkg::BackW-1:0]    out_backup_address;
  logic                          out_to_grid;
  logic                          out_last;
  logic                          out_empty_res;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [shag_pkg::IdxW-1:0]     cfg_index;
  logic [shag_pkg::DataW-1:0]    cfg_data;

  halo_walk_t   walk;
  halo_result_t seen;
  bit           quiet;
  int           idle_pct;
  int           items_sent;
  int           ready_hold;
  int           cycle_count;

  stencil_halo_address_generator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_step_num        (in_step_num),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_grid_address   (out_grid_address),
    .out_backup_address (out_backup_address),
    .out_to_grid        (out_to_grid),
    .out_last           (out_last),
    .out_empty_res      (out_empty_res),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: ready runs and stall bursts, always ready near the end
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 17);
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.grid    = out_grid_address;
      seen.backup  = out_backup_address;
      seen.to_grid = out_to_grid;
      seen.last    = out_last;
      seen.empty   = out_empty_res;
      walk.match(seen);
    end
  end

  task automatic send_request(input logic [shag_pkg::TsW-1:0] ts);
    if (!quiet && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_step_num <= ts;
    do @(posedge clk); while (!in_ready);
    walk.step(ts);
    items_sent++;
  endtask

  // hold off new requests until every owed pair has come back and the block settles
  task automatic drain();
    in_valid <= 1'b0;
    while (walk.pending_addresses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input shag_pkg::cfg_t s);
    logic [shag_pkg::DataW-1:0] value, keep;
    for (int r = 0; r < 8; r++) begin
      case (r[shag_pkg::IdxW-1:0])
        shag_pkg::REG_HALF:  begin value = 32'(s.half);    keep = 32'h1f;        end
        shag_pkg::REG_BOUND: begin value = 32'(s.bound);   keep = 32'hff;        end
        shag_pkg::REG_WX:    begin value = 32'(s.wx);      keep = 32'h7ff;       end
        shag_pkg::REG_WZ:    begin value = 32'(s.wz);      keep = 32'h7ff;       end
        shag_pkg::REG_WY:    begin value = 32'(s.wy);      keep = 32'h7ff;       end
        shag_pkg::REG_3D:    begin value = 32'(s.three_d); keep = 32'h1;         end
        shag_pkg::REG_BSIZE: begin value = s.bsize;        keep = 32'hffff_ffff; end
        shag_pkg::REG_MODE:  begin value = 32'(s.restore); keep = 32'h1;         end
        default:             begin value = '0;             keep = '0;            end
      endcase
      // bits above the register width are don't-care
      if ($urandom_range(0, 1) == 1) value = value | ($urandom() & ~keep);
      cfg_valid <= 1'b1;
      cfg_index <= r[shag_pkg::IdxW-1:0];
      cfg_data  <= value;
      do @(posedge clk); while (!cfg_ready);
      walk.write_reg(r[shag_pkg::IdxW-1:0], value);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic shag_pkg::cfg_t make_settings(int half, int bound, int wx, int wz,
                                                   int wy, int three_d,
                                                   logic [shag_pkg::BsW-1:0] bsize,
                                                   int restore);
    shag_pkg::cfg_t s;
    s.half    = half[shag_pkg::HalfW-1:0];
    s.bound   = bound[shag_pkg::BoundW-1:0];
    s.wx      = wx[shag_pkg::DimW-1:0];
    s.wz      = wz[shag_pkg::DimW-1:0];
    s.wy      = wy[shag_pkg::DimW-1:0];
    s.three_d = three_d[0];
    s.bsize   = bsize;
    s.restore = restore[0];
    return s;
  endfunction

  // mostly small windows so walks finish; some wide ones, often empty
  function automatic shag_pkg::cfg_t random_settings();
    shag_pkg::cfg_t s;
    bit             wide;
    wide      = ($urandom_range(0, 9) < 3);
    s.half    = shag_pkg::HalfW'(wide ? $urandom_range(0, 31) : $urandom_range(1, 4));
    s.bound   = shag_pkg::BoundW'(wide ? $urandom_range(0, 255) : $urandom_range(0, 3));
    s.wx      = shag_pkg::DimW'(wide ? $urandom_range(0, 1024) : $urandom_range(1, 12));
    s.wz      = shag_pkg::DimW'(wide ? $urandom_range(0, 1024) : $urandom_range(1, 12));
    s.wy      = shag_pkg::DimW'(wide ? $urandom_range(0, 1024) : $urandom_range(1, 8));
    s.three_d = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0:       s.bsize = '0;
      1:       s.bsize = '1;
      default: s.bsize = $urandom();
    endcase
    s.restore = 1'($urandom_range(0, 1));
    return s;
  endfunction

  initial begin
    logic [shag_pkg::TsW-1:0] ts;
    int                       burst;
    int                       stop_at;
    walk        = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_step_num = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    quiet       = 1'b0;
    idle_pct    = 25;
    items_sent  = 0;
    ready_hold  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: the strip offset exceeds the 1x1x1 window, empty walk
    send_request(16'hffff);
    drain();
    // 2-D, one element per strip: a pair on the x faces, then one on the z faces
    load_settings(make_settings(1, 0, 3, 3, 1, 0, 5, 0));
    repeat (4) send_request(16'h1234);
    drain();
    // 3-D with a boundary, restore direction: one pair on each face
    load_settings(make_settings(1, 1, 5, 5, 3, 1, 32'hffff_ffff, 1));
    repeat (6) send_request(16'hffff);
    drain();
    // zero strip width, then zero-sized windows
    load_settings(make_settings(0, 0, 8, 8, 8, 1, 7, 0));
    send_request(16'h0001);
    drain();
    load_settings(make_settings(2, 0, 0, 0, 6, 0, 7, 1));
    send_request(16'h8000);
    drain();
    // largest window and boundary; grid addresses stay below 2^30
    load_settings(make_settings(16, 255, 1024, 1024, 1024, 1, 32'hffff_ffff, 0));
    repeat (3) send_request(16'hffff);
    drain();
    // registers rewritten mid-walk, past their nominal range
    load_settings(make_settings(31, 255, 2047, 2047, 2047, 1, 32'h0001_0000, 1));
    repeat (3) send_request(16'h5a5a);
    drain();
    // tiny window under a wide boundary: coordinates go negative, counters roll over
    load_settings(make_settings(1, 255, 4, 4, 4, 1, 3, 0));
    while (walk.walking) send_request(16'h0000);
    drain();

    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      load_settings(random_settings());
      idle_pct = 25 * $urandom_range(0, 2);
      burst    = $urandom_range(10, 80);
      repeat (burst) begin
        if (items_sent >= stop_at - QUIET_ITEMS) quiet = 1'b1;
        ts = shag_pkg::TsW'($urandom());
        if ($urandom_range(0, 7) == 0) ts = ts[0] ? '1 : '0;
        send_request(ts);
      end
      drain();
    end

    if (walk.mismatches == 0 && walk.pending_addresses.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
